/* rtl/core/assert_macros.svh */
// Assertion macros shared by the divider RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clk edge outside reset.
`define SID_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Check that cond never holds on a rising clk edge outside reset.
`define SID_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

/* rtl/core/sid_pkg.sv */
// Constants and types of the signed integer divider.
package sid_pkg;

	localparam int DATA_WIDTH = 32;

	typedef enum logic [1:0] {
		SID_IDLE,
		SID_DIV,
		SID_FIX
	} sid_state_t;

endpackage

/* rtl/core/sid_in_if.sv */
// Operand channel: dividend and divisor words with valid/ready.
interface sid_in_if #(
	parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] dividend;
	logic signed [DATA_WIDTH-1:0] divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink (input valid, input dividend, input divisor, output ready);
endinterface

/* rtl/core/sid_out_if.sv */
// Result channel: quotient word and divide-by-zero flag with valid/ready.
interface sid_out_if #(
	parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] quotient;
	logic                         divide_by_zero;

	modport source (output valid, output quotient, output divide_by_zero, input ready);
	modport sink (input valid, input quotient, input divide_by_zero, output ready);
endinterface

/* rtl/core/signed_integer_divider_core.sv */
// Signed integer divider: restoring radix-2 division, one quotient bit per cycle.
//
//   channel   dir  words carried
//   operand   in   dividend, divisor
//   result    out  quotient, divide_by_zero
//
// A word is taken in idle, then runs DATA_WIDTH iterations of the shared
// subtract-and-shift step, then a sign fix-up step that loads the result register.
// A new word is taken only once the previous one has left fix-up and the state
// machine is back in idle. arst_n clears the state machine and the result valid
// flag. operand.ready is high only in idle; a held result stalls the fix-up step,
// and the next word is taken while the result waits.
`include "assert_macros.svh"

module signed_integer_divider_core #(
	parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	sid_in_if.sink    operand,
	sid_out_if.source result
);

	localparam int                CNT_W    = $clog2(DATA_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);
	localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	sid_pkg::sid_state_t state_q, state_d;

	logic [DATA_WIDTH-1:0] num_q;
	logic [DATA_WIDTH-1:0] den_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  neg_q;
	logic                  dbz_q;
	logic                  ovf_q;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] quotient_q;
	logic                  out_dbz_q;

	logic                  accept;
	logic                  load_out;
	logic [DATA_WIDTH-1:0] a_u;
	logic [DATA_WIDTH-1:0] b_u;
	logic [DATA_WIDTH-1:0] a_mag;
	logic [DATA_WIDTH-1:0] b_mag;
	logic [DATA_WIDTH-1:0] trial;
	logic [DATA_WIDTH:0]   diff;
	logic                  q_bit;
	logic [DATA_WIDTH-1:0] q_fixed;

	assign a_u   = operand.dividend;
	assign b_u   = operand.divisor;
	assign a_mag = a_u[DATA_WIDTH-1] ? DATA_WIDTH'(~a_u + DATA_WIDTH'(1)) : a_u;
	assign b_mag = b_u[DATA_WIDTH-1] ? DATA_WIDTH'(~b_u + DATA_WIDTH'(1)) : b_u;

	assign trial = {rem_q[DATA_WIDTH-2:0], num_q[DATA_WIDTH-1]};
	assign diff  = {1'b0, trial} - {1'b0, den_q};
	assign q_bit = !diff[DATA_WIDTH];

	always_comb begin
		priority if (dbz_q) begin
			q_fixed = '0;
		end else if (ovf_q) begin
			q_fixed = MAX_POS;
		end else if (neg_q) begin
			q_fixed = DATA_WIDTH'(~num_q + DATA_WIDTH'(1));
		end else begin
			q_fixed = num_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sid_pkg::SID_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		operand.ready = 1'b0;
		accept        = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			sid_pkg::SID_IDLE: begin
				operand.ready = 1'b1;
				accept        = operand.valid;
				if (operand.valid) begin
					state_d = sid_pkg::SID_DIV;
				end
			end
			sid_pkg::SID_DIV: begin
				if (cnt_q == '0) begin
					state_d = sid_pkg::SID_FIX;
				end
			end
			sid_pkg::SID_FIX: begin
				load_out = !out_valid_q || result.ready;
				if (load_out) begin
					state_d = sid_pkg::SID_IDLE;
				end
			end
			default: begin
				state_d = sid_pkg::SID_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			num_q <= a_mag;
			den_q <= b_mag;
			rem_q <= '0;
			cnt_q <= CNT_LAST;
			neg_q <= a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
			dbz_q <= (b_u == '0);
			ovf_q <= (a_u == MIN_NEG) && (b_u == '1);
		end else if (state_q == sid_pkg::SID_DIV) begin
			num_q <= {num_q[DATA_WIDTH-2:0], q_bit};
			rem_q <= q_bit ? diff[DATA_WIDTH-1:0] : trial;
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			quotient_q <= q_fixed;
			out_dbz_q  <= dbz_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.quotient       = quotient_q;
	assign result.divide_by_zero = out_dbz_q;

	`SID_ASSERT(a_accept_starts_div, clk, arst_n,
		accept |=> state_q == sid_pkg::SID_DIV, "accepted word did not start division")
	`SID_ASSERT(a_last_step_to_fix, clk, arst_n,
		(state_q == sid_pkg::SID_DIV && cnt_q == '0) |=> state_q == sid_pkg::SID_FIX,
		"last quotient bit did not lead to fix-up")
	`SID_ASSERT(a_load_sets_valid, clk, arst_n,
		load_out |=> out_valid_q, "fix-up did not present a result")
	`SID_ASSERT(a_dbz_zero_quotient, clk, arst_n,
		(out_valid_q && out_dbz_q) |-> quotient_q == '0,
		"divide-by-zero result with nonzero quotient")
	`SID_ASSERT_NEVER(a_no_overwrite, clk, arst_n,
		load_out && out_valid_q && !result.ready, "pending result overwritten")

endmodule

/* verif/tb.sv */
// Testbench for signed_integer_divider_core: directed and random words against a predictor.
`timescale 1ns / 100ps

module tb;

	localparam int W = sid_pkg::DATA_WIDTH;
	localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINUS_ONE = '1;
	localparam int DRAIN_CYCLES = W + 8;
	localparam longint CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic signed [W-1:0] quotient;
		logic                divide_by_zero;
	} quotient_word_t;

	logic clk;
	logic arst_n;

	sid_in_if  operand_bus ();
	sid_out_if result_bus ();

	signed_integer_divider_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand_bus),
		.result  (result_bus)
	);

	quotient_word_t pending_quotients[$];
	bit gaps_on = 1'b1;
	int errors = 0;
	int words_sent = 0;
	int results_checked = 0;
	int zero_divisor_words = 0;
	int saturated_words = 0;
	longint cycles = 0;

	function automatic quotient_word_t predict_quotient(logic [W-1:0] num_in, logic [W-1:0] den_in);
		quotient_word_t word;
		logic [W-1:0] num;
		logic [W-1:0] den;
		logic [W-1:0] quo;
		logic [W:0] part;
		logic negative;
		word.divide_by_zero = 1'b0;
		if (den_in == '0) begin
			word.quotient = '0;
			word.divide_by_zero = 1'b1;
			return word;
		end
		if (num_in == MOST_NEG && den_in == MINUS_ONE) begin
			word.quotient = MOST_POS;
			return word;
		end
		negative = num_in[W-1] ^ den_in[W-1];
		num = num_in[W-1] ? -num_in : num_in;
		den = den_in[W-1] ? -den_in : den_in;
		part = '0;
		quo = '0;
		for (int i = W - 1; i >= 0; i--) begin
			part = {part[W-1:0], num[i]};
			quo = {quo[W-2:0], 1'b0};
			if (part >= {1'b0, den}) begin
				part = part - {1'b0, den};
				quo[0] = 1'b1;
			end
		end
		word.quotient = negative ? -quo : quo;
		return word;
	endfunction

	function automatic int draw_gap();
		if (!gaps_on)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic logic signed [W-1:0] random_operand();
		logic [W-1:0] value;
		int unsigned bits;
		if ($urandom_range(0, 15) == 0) begin
			case ($urandom_range(0, 4))
				0: return MOST_NEG;
				1: return MOST_POS;
				2: return MINUS_ONE;
				3: return '0;
				default: return 1;
			endcase
		end
		bits = $urandom_range(1, W);
		value = W'({$urandom, $urandom});
		value = value & ({W{1'b1}} >> (W - bits));
		if ($urandom_range(0, 1))
			value = -value;
		return value;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still pending",
				cycles, pending_quotients.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int gap;
		result_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				result_bus.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_bus.ready <= 1'b1;
			do @(posedge clk); while (!(result_bus.valid && result_bus.ready));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		quotient_word_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_quotients.size() == 0) begin
				$error("Result word with nothing pending: quotient %0d divide_by_zero %0b",
					result_bus.quotient, result_bus.divide_by_zero);
				errors++;
			end else begin
				want = pending_quotients.pop_front();
				results_checked++;
				if (result_bus.quotient !== want.quotient) begin
					$error("quotient: expected %0d, actual %0d", want.quotient,
						result_bus.quotient);
					errors++;
				end
				if (result_bus.divide_by_zero !== want.divide_by_zero) begin
					$error("divide_by_zero: expected %0b, actual %0b", want.divide_by_zero,
						result_bus.divide_by_zero);
					errors++;
				end
			end
		end
	end

	task automatic send_word(input logic signed [W-1:0] num, input logic signed [W-1:0] den);
		int gap;
		quotient_word_t want;
		gap = draw_gap();
		if (gap > 0) begin
			operand_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operand_bus.valid <= 1'b1;
		operand_bus.dividend <= num;
		operand_bus.divisor <= den;
		do @(posedge clk); while (!(operand_bus.valid && operand_bus.ready));
		want = predict_quotient(num, den);
		pending_quotients.insert(pending_quotients.size(), want);
		words_sent++;
		if (want.divide_by_zero)
			zero_divisor_words++;
		if (num == MOST_NEG && den == MINUS_ONE)
			saturated_words++;
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		operand_bus.valid <= 1'b0;
		while (pending_quotients.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_corner_operands();
		send_word(0, 1);
		send_word(1, 1);
		send_word(-1, 1);
		send_word(MOST_POS, 1);
		send_word(MOST_NEG, 1);
		send_word(MOST_NEG, MOST_NEG);
		send_word(MOST_POS, MOST_NEG);
		send_word(MOST_POS, MOST_POS);
		send_word(MOST_POS, MINUS_ONE);
		send_word(1, MOST_POS);
		send_word(-1, MOST_NEG);
		send_word(MOST_NEG, 2);
		send_word(MOST_NEG, MOST_POS);
		send_word(7, 2);
		send_word(-7, 2);
		send_word(7, -2);
		send_word(-7, -2);
		send_word(100, -3);
		send_word(-100, 7);
	endtask

	task automatic test_zero_divisor();
		send_word(5, 0);
		send_word(0, 0);
		send_word(MOST_NEG, 0);
		send_word(MOST_POS, 0);
	endtask

	task automatic test_overflow_saturation();
		send_word(MOST_NEG, MINUS_ONE);
		send_word(MOST_NEG + 1, MINUS_ONE);
	endtask

	task automatic test_random_mixed_widths(input int count);
		for (int i = 0; i < count; i++)
			send_word(random_operand(), random_operand());
	endtask

	task automatic test_random_full_range(input int count);
		for (int i = 0; i < count; i++)
			send_word($urandom, $urandom);
	endtask

	task automatic test_back_to_back(input int count);
		gaps_on = 1'b0;
		test_random_mixed_widths(count);
		gaps_on = 1'b1;
	endtask

	task automatic test_pause_until_drained(input int count);
		for (int i = 0; i < count; i++) begin
			send_word(random_operand(), random_operand());
			if ($urandom_range(0, 3) == 0)
				wait_all_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		operand_bus.valid <= 1'b0;
		operand_bus.dividend <= '0;
		operand_bus.divisor <= '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_corner_operands();
		test_zero_divisor();
		test_overflow_saturation();
		wait_all_results();
		test_random_mixed_widths(350);
		test_back_to_back(120);
		test_random_full_range(150);
		test_pause_until_drained(80);

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d operand words and checked %0d results in %0d cycles",
			words_sent, results_checked, cycles);
		$display("Covered %0d divide-by-zero words and %0d saturating overflow words",
			zero_divisor_words, saturated_words);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* signed_integer_divider_core.f */
+incdir+rtl/core
rtl/core/sid_pkg.sv
rtl/core/sid_in_if.sv
rtl/core/sid_out_if.sv
rtl/core/signed_integer_divider_core.sv
verif/tb.sv
